// File: rtl/core/swnm_pkg.sv
package swnm_pkg;

  localparam int NAME_BYTES_DEF    = 14;
  localparam int PATTERN_BYTES_DEF = 16;

  localparam logic [7:0] STAR_BYTE = 8'd42;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PATTERN_LOW  = 2'd0;
  localparam cfg_idx_t CFG_PATTERN_HIGH = 2'd1;
  localparam cfg_idx_t CFG_PATTERN_LEN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rem_zero;
  } dp_status_t;

endpackage

// File: rtl/core/swnm_ifs.sv
interface swnm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_low_bytes;
  logic [47:0] name_high_bytes;
  logic [3:0]  name_length;

  modport source (output valid, name_low_bytes, name_high_bytes, name_length, input ready);
  modport sink   (input valid, name_low_bytes, name_high_bytes, name_length, output ready);
endinterface

interface swnm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface swnm_cfg_if;
  import swnm_pkg::*;
  cfg_idx_t    index;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/swnm_cfg_regs.sv
module swnm_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  swnm_cfg_if.sink    cfg_if,
  output logic [63:0] pattern_low_bytes,
  output logic [63:0] pattern_high_bytes,
  output logic [4:0]  pattern_length
);
  import swnm_pkg::*;

  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;
  logic [4:0]  pat_len_r;
  logic        wr;

  assign cfg_if.ready = 1'b1;
  assign wr           = cfg_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (wr) begin
      case (cfg_if.index)
        CFG_PATTERN_LOW:  pat_lo_r  <= cfg_if.data;
        CFG_PATTERN_HIGH: pat_hi_r  <= cfg_if.data;
        CFG_PATTERN_LEN:  pat_len_r <= cfg_if.data[4:0];
        default: ;
      endcase
    end
  end

  assign pattern_low_bytes  = pat_lo_r;
  assign pattern_high_bytes = pat_hi_r;
  assign pattern_length     = pat_len_r;

`ifndef NO_ASSERTIONS
  a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_if.valid && cfg_if.index == CFG_PATTERN_LEN) |=> pat_len_r == $past(cfg_if.data[4:0]))
    else $error("pattern length write lost");
  a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_if.valid && cfg_if.index == CFG_PATTERN_LEN) |=> $stable(pat_len_r))
    else $error("pattern length changed without write");
  a_low_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_if.valid && cfg_if.index == CFG_PATTERN_LOW) |=> $stable(pat_lo_r))
    else $error("pattern low bytes changed without write");
`endif

endmodule

// File: rtl/core/swnm_ctrl.sv
module swnm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  swnm_pkg::dp_status_t  sts,
  output swnm_pkg::ctrl_cmd_t   cmd
);
  import swnm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.rem_zero) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) state_nxt = in_valid ? ST_RUN : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step   = !sts.rem_zero;
        cmd.finish = sts.rem_zero;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.load  = out_ready && in_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_RUN)
    else $error("load did not start a run");
  a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == ST_DONE && out_valid)
    else $error("finish did not present a result");
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_RUN)
    else $error("result raised without a run");
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule

// File: rtl/core/swnm_dp.sv
module swnm_dp #(
  parameter int NAME_BYTES    = swnm_pkg::NAME_BYTES_DEF,
  parameter int PATTERN_BYTES = swnm_pkg::PATTERN_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [63:0]          pattern_low_bytes,
  input  logic [63:0]          pattern_high_bytes,
  input  logic [4:0]           pattern_length,
  input  logic [63:0]          name_low_bytes,
  input  logic [47:0]          name_high_bytes,
  input  logic [3:0]           name_length,
  input  swnm_pkg::ctrl_cmd_t  cmd,
  output swnm_pkg::dp_status_t sts,
  output logic                 matched
);
  import swnm_pkg::*;

  localparam int LW = $clog2(NAME_BYTES + 1);
  localparam int PW = $clog2(PATTERN_BYTES + 1);

  logic [127:0]              pat_bits;
  logic [111:0]              name_bits;
  logic [7:0]                pat_byte [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0]  is_star;
  logic [PATTERN_BYTES-1:0]  in_pat;
  logic [PW-1:0]             m;

  logic [8*NAME_BYTES-1:0]   name_r;
  logic [LW-1:0]             rem_r;
  logic [PATTERN_BYTES:0]    act_r;
  logic                      matched_r;

  logic [PATTERN_BYTES:0]    act_step;
  logic [PATTERN_BYTES:0]    act_nxt;
  logic [PATTERN_BYTES:0]    act_seed;
  logic [PATTERN_BYTES:0]    act_raw;
  logic [LW-1:0]             n_sat;
  logic [7:0]                cur_byte;

  assign pat_bits  = {pattern_high_bytes, pattern_low_bytes};
  assign name_bits = {name_high_bytes, name_low_bytes};
  assign cur_byte  = name_r[7:0];

  assign m = (pattern_length > 5'(PATTERN_BYTES)) ? PW'(PATTERN_BYTES)
                                                  : pattern_length[PW-1:0];
  assign n_sat = (name_length > 4'(NAME_BYTES)) ? LW'(NAME_BYTES) : name_length[LW-1:0];

  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      pat_byte[j] = pat_bits[8*j +: 8];
      is_star[j]  = (pat_bits[8*j +: 8] == STAR_BYTE);
      in_pat[j]   = (PW'(j) < m);
    end
  end

  always_comb begin
    act_seed    = '0;
    act_seed[0] = 1'b1;
    act_step    = '0;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (act_r[j] && in_pat[j]) begin
        if (is_star[j]) begin
          act_step[j] = 1'b1;
        end else if (pat_byte[j] == cur_byte) begin
          act_step[j+1] = 1'b1;
        end
      end
    end
    act_raw = cmd.load ? act_seed : act_step;
    act_nxt = act_raw;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (act_nxt[j] && is_star[j] && in_pat[j]) act_nxt[j+1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.load) begin
      rem_r <= n_sat;
    end else if (cmd.step) begin
      rem_r <= rem_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.step) begin
      act_r <= act_nxt;
    end
    if (cmd.load) begin
      name_r <= name_bits[8*NAME_BYTES-1:0];
    end else if (cmd.step) begin
      name_r <= name_r >> 8;
    end
    if (cmd.finish) begin
      matched_r <= act_r[m];
    end
  end

  assign sts.rem_zero = (rem_r == '0);
  assign matched      = matched_r;

`ifndef NO_ASSERTIONS
  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> act_r[0])
    else $error("start position not active after load");
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> rem_r != '0)
    else $error("step with no name bytes left");
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> rem_r == $past(rem_r) - LW'(1))
    else $error("remaining count did not advance");
`endif

endmodule

// File: rtl/core/star_wildcard_name_match.sv
// Star-only wildcard matcher for short file names. Write the pattern through
// cfg_if (index 0: bytes 0-7, index 1: bytes 8-15, index 2: length) while the
// block is idle; '*' matches any run of name bytes, adjacent stars act as one.
// Each name beat (lengths above NAME_BYTES count as NAME_BYTES) goes through a
// load step, one step per name byte through the pattern position vector, and a
// step that registers the result, before its result beat is offered. A new
// name beat is taken in the same cycle the result is taken, so no name is taken
// while the last one is still being matched or its result is still waiting.
module star_wildcard_name_match #(
  parameter int NAME_BYTES    = swnm_pkg::NAME_BYTES_DEF,
  parameter int PATTERN_BYTES = swnm_pkg::PATTERN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  swnm_in_if.sink     in_if,
  swnm_out_if.source  out_if,
  swnm_cfg_if.sink    cfg_if
);
  import swnm_pkg::*;

  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;
  ctrl_cmd_t   cmd;
  dp_status_t  sts;

  swnm_cfg_regs u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_if             (cfg_if),
    .pattern_low_bytes  (pat_lo),
    .pattern_high_bytes (pat_hi),
    .pattern_length     (pat_len)
  );

  swnm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swnm_dp #(
    .NAME_BYTES    (NAME_BYTES),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .pattern_low_bytes  (pat_lo),
    .pattern_high_bytes (pat_hi),
    .pattern_length     (pat_len),
    .name_low_bytes     (in_if.name_low_bytes),
    .name_high_bytes    (in_if.name_high_bytes),
    .name_length        (in_if.name_length),
    .cmd                (cmd),
    .sts                (sts),
    .matched            (out_if.matched)
  );

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("name beat taken while result stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(out_if.matched))
    else $error("stalled result beat changed");
  a_in_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !out_if.valid)
    else $error("result offered right after a name beat");
`endif

endmodule
